/* design/prcc_pkg.sv */
package prcc_pkg;

   // Widths of the counters and the configuration registers.
   localparam int unsigned CountWidth = 17;
   localparam int unsigned LimitWidth = 16;

   // Configuration register indexes and reset values.
   localparam logic CSR_TOTAL_LIMIT = 1'b0;
   localparam logic CSR_LINE_LIMIT  = 1'b1;
   localparam logic [LimitWidth-1:0] TOTAL_LIMIT_RESET = 16'd16384;
   localparam logic [LimitWidth-1:0] LINE_LIMIT_RESET  = 16'd8192;

   // Characters that the status line parser looks for.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam int unsigned PrefixLength = 7;
   localparam int unsigned CodeLength   = 3;

   localparam logic [CountWidth-1:0] COUNT_MAX = {CountWidth{1'b1}};

   typedef enum logic [1:0] {
      ACTION_DATA    = 2'd0,
      ACTION_EOS     = 2'd1,
      ACTION_RESTART = 2'd2,
      ACTION_UNUSED  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      VERDICT_PARSING      = 3'd0,
      VERDICT_OK           = 3'd1,
      VERDICT_LIMIT        = 3'd2,
      VERDICT_MALFORMED    = 3'd3,
      VERDICT_NON200       = 3'd4,
      VERDICT_CLOSED_EARLY = 3'd5,
      VERDICT_CLOSED_MID   = 3'd6
   } verdict_type;

   typedef enum logic [1:0] {
      PHASE_STATUS  = 2'd0,
      PHASE_HEADERS = 2'd1,
      PHASE_DONE    = 2'd2
   } phase_type;

   // Complete parse state of one connection.
   typedef struct packed {
      phase_type              phase;
      logic [CountWidth-1:0]  total_seen;
      logic [CountWidth-1:0]  line_length;
      logic                   pending_cr;
      logic                   prefix_matched;
      logic                   space_found;
      logic [1:0]             code_chars_seen;
      logic                   code_matched;
      logic                   status_nonempty;
      verdict_type            held_verdict;
   } state_type;

   // Result of one transaction.
   typedef struct packed {
      logic        consumed;
      logic        finished;
      verdict_type verdict;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:           PHASE_STATUS,
      total_seen:      '0,
      line_length:     '0,
      pending_cr:      1'b0,
      prefix_matched:  1'b1,
      space_found:     1'b0,
      code_chars_seen: 2'd0,
      code_matched:    1'b1,
      status_nonempty: 1'b0,
      held_verdict:    VERDICT_PARSING
   };

   // Expected character of the "HTTP/1." prefix at a given position.
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h48;  // H
         3'd1:    ch = 8'h54;  // T
         3'd2:    ch = 8'h54;  // T
         3'd3:    ch = 8'h50;  // P
         3'd4:    ch = 8'h2F;  // /
         3'd5:    ch = 8'h31;  // 1
         3'd6:    ch = 8'h2E;  // .
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Expected character of the "200" status code at a given position.
   function automatic logic [7:0] code_char(input logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = 8'h32;  // 2
         default: ch = 8'h30;  // 0
      endcase
      return ch;
   endfunction

   // Applies one text character at a content position of the status line.
   function automatic state_type take_text(input state_type st, input logic [7:0] ch,
                                           input logic [CountWidth-1:0] pos);
      state_type nxt;
      nxt = st;
      if (st.phase == PHASE_STATUS) begin
         if (pos < CountWidth'(PrefixLength) && ch != prefix_char(pos[2:0])) begin
            nxt.prefix_matched = 1'b0;
         end
         if (st.space_found) begin
            if (st.code_chars_seen < 2'(CodeLength)) begin
               if (ch != code_char(st.code_chars_seen)) begin
                  nxt.code_matched = 1'b0;
               end
               nxt.code_chars_seen = st.code_chars_seen + 2'd1;
            end
         end else if (ch == CHAR_SPACE) begin
            nxt.space_found = 1'b1;
         end
      end
      return nxt;
   endfunction

endpackage

/* design/prcc_step.sv */
module prcc_step (
   input  prcc_pkg::state_type              cur_state,
   input  logic [1:0]                       action,
   input  logic [7:0]                       data_byte,
   input  logic [prcc_pkg::LimitWidth-1:0]  total_limit,
   input  logic [prcc_pkg::LimitWidth-1:0]  line_limit,
   output prcc_pkg::state_type              nxt_state,
   output prcc_pkg::result_type             result
);
   import prcc_pkg::*;

   logic [CountWidth-1:0] seen;
   logic [CountWidth-1:0] len;
   logic [CountWidth-1:0] content_len;
   logic                  consumed;
   state_type             st;

   assign len         = cur_state.line_length;
   assign content_len = len - CountWidth'(1);

   // Saturating count of reply bytes including this one.
   assign seen = (cur_state.total_seen == COUNT_MAX) ? cur_state.total_seen
                                                     : cur_state.total_seen + CountWidth'(1);

   // Next parse state for one transaction.
   always_comb begin
      st       = cur_state;
      consumed = 1'b0;
      unique case (action_type'(action))
         ACTION_RESTART: begin
            st = STATE_RESET;
         end
         ACTION_EOS: begin
            if (cur_state.phase != PHASE_DONE) begin
               st.held_verdict = (cur_state.phase == PHASE_STATUS || !cur_state.status_nonempty)
                                 ? VERDICT_CLOSED_EARLY : VERDICT_CLOSED_MID;
               st.phase = PHASE_DONE;
            end
         end
         ACTION_DATA: begin
            if (cur_state.phase != PHASE_DONE) begin
               consumed      = 1'b1;
               st.total_seen = seen;
               if (seen > {1'b0, total_limit} || len >= {1'b0, line_limit}) begin
                  st.held_verdict = VERDICT_LIMIT;
                  st.phase        = PHASE_DONE;
               end else if (cur_state.pending_cr && data_byte == CHAR_LF) begin
                  // The line ends; content_len is its length without CR LF.
                  if (cur_state.phase == PHASE_STATUS) begin
                     if (!cur_state.prefix_matched || content_len < CountWidth'(PrefixLength)
                         || !cur_state.space_found
                         || cur_state.code_chars_seen < 2'(CodeLength)) begin
                        st.held_verdict = VERDICT_MALFORMED;
                     end else if (!cur_state.code_matched) begin
                        st.held_verdict = VERDICT_NON200;
                     end else begin
                        st.held_verdict = VERDICT_OK;
                     end
                     st.status_nonempty = (content_len != '0);
                     st.phase           = PHASE_HEADERS;
                  end else if (content_len == '0) begin
                     st.phase = PHASE_DONE;
                  end
                  st.line_length = '0;
                  st.pending_cr  = 1'b0;
               end else begin
                  // A held CR that is not followed by LF is ordinary text.
                  if (cur_state.pending_cr) begin
                     st = take_text(st, CHAR_CR, content_len);
                  end
                  if (data_byte == CHAR_CR) begin
                     st.pending_cr = 1'b1;
                  end else begin
                     st.pending_cr = 1'b0;
                     st = take_text(st, data_byte, len);
                  end
                  st.line_length = len + CountWidth'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign nxt_state       = st;
   assign result.consumed = consumed;
   assign result.finished = (st.phase == PHASE_DONE);
   assign result.verdict  = (st.phase == PHASE_DONE) ? st.held_verdict : VERDICT_PARSING;

endmodule

/* design/proxy_connect_reply_checker.sv */
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_action, req_data_byte
// rsp_      out        rsp_valid/rsp_stall  rsp_consumed, rsp_finished, rsp_verdict
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// Each transaction passes through the input register and then the result register,
// from which its result is offered. The state update is done in a single pass.
// One transaction is accepted per cycle unless a stalled result holds it back.
// Reset restores the limit registers and the status line parse state.
// A stalled result holds the result register, and the input register backs up behind it.
module proxy_connect_reply_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_action,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_consumed,
   output logic                             rsp_finished,
   output logic [2:0]                       rsp_verdict,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic [prcc_pkg::LimitWidth-1:0]  csr_data
);
   import prcc_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [1:0]            in_action_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_result_ff;
   state_type             state_ff;
   state_type             state_in;
   result_type            step_result;
   logic [LimitWidth-1:0] total_limit_ff;
   logic [LimitWidth-1:0] line_limit_ff;
   logic                  advance;
   logic                  req_accept;

   // The input register moves on when the result register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   prcc_step u_step (
      .cur_state   (state_ff),
      .action      (in_action_ff),
      .data_byte   (in_byte_ff),
      .total_limit (total_limit_ff),
      .line_limit  (line_limit_ff),
      .nxt_state   (state_in),
      .result      (step_result)
   );

   // Handshake control, parse state and limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= STATE_RESET;
         total_limit_ff <= TOTAL_LIMIT_RESET;
         line_limit_ff  <= LINE_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TOTAL_LIMIT: total_limit_ff <= csr_data;
               CSR_LINE_LIMIT:  line_limit_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_data_byte;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_consumed = out_result_ff.consumed;
   assign rsp_finished = out_result_ff.finished;
   assign rsp_verdict  = out_result_ff.verdict;

endmodule
